### rtl/core/gcs_pkg.sv
package gcs_pkg;

    // fixed field widths of the request and result streams
    localparam int NODE_W    = 6;
    localparam int COLOUR_W  = 5;
    localparam int NCOL_W    = 6;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    localparam logic [NCOL_W-1:0] NCOL_RESET = 6'd8;

    // request kinds carried on s_axis_tuser
    localparam logic REQ_EDGE   = 1'b0;
    localparam logic REQ_COLOUR = 1'b1;

endpackage

### rtl/core/gcs_adj_ram.sv
module gcs_adj_ram
#(
    parameter int NODES = 64,
    parameter int AW    = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [NODES-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [NODES-1:0] wr_data
);

    logic [NODES-1:0] mem [NODES];
    logic [NODES-1:0] row_vld_reg;
    logic [NODES-1:0] rd_data_reg;
    logic             rd_vld_reg;

    // row valid bits: a row never written reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= row_vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

### rtl/core/gcs_colour_store.sv
module gcs_colour_store
#(
    parameter int NODES = 64,
    parameter int AW    = 6,
    parameter int CW    = 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [CW-1:0] rd_colour,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [CW-1:0] wr_colour,
    input  logic [AW-1:0] chk_addr,
    output logic          chk_alloc,
    input  logic [AW-1:0] own_addr,
    output logic          own_alloc
);

    logic [CW-1:0]    mem [NODES];
    logic [CW-1:0]    rd_colour_reg;
    logic [NODES-1:0] alloc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_reg <= '0;
        end
        else if (wr_en)
        begin
            alloc_reg[wr_addr] <= 1'b1;
        end
    end

    // colour entries hold garbage until their allocated bit is set
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_colour;
        end
        if (rd_en)
        begin
            rd_colour_reg <= mem[rd_addr];
        end
    end

    assign rd_colour = rd_colour_reg;
    assign chk_alloc = alloc_reg[chk_addr];
    assign own_alloc = alloc_reg[own_addr];

endmodule

### rtl/core/gcs_pick.sv
module gcs_pick
#(
    parameter int MAX_COLOURS = 32,
    parameter int CW          = 5
)
(
    input  logic [MAX_COLOURS-1:0] free_mask,
    output logic                   found,
    output logic [CW-1:0]          idx
);

    logic [MAX_COLOURS-1:0] lowest;

    // isolate the lowest free colour, then encode it
    assign lowest = free_mask & (~free_mask + MAX_COLOURS'(1));
    assign found  = |free_mask;

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < MAX_COLOURS; i++)
        begin
            if (lowest[i])
            begin
                idx = idx | CW'(i);
            end
        end
    end

endmodule

### rtl/core/graph_colour_select.sv
// select stage of a graph-colouring register allocator. edge requests
// (s_axis_tuser low) set one bit of a directed adjacency matrix kept in a
// row-wide memory; colour requests (s_axis_tuser high) pick the lowest free
// colour below k = min(num_colours, MAX_COLOURS) for a node and return one
// result carrying the node, the colour and a found flag. ids below k are
// physical registers. an edge request reads the row on accept, then writes it
// back. a colour request runs accept, which issues the row read, ST_ROW_WAIT
// to latch the row, ST_SCAN over every node through the adjacency and colour
// memory read ports, ST_SCAN_END to drain the scan pipeline and ST_PICK to
// pick and store; ST_PICK holds while the previous result still waits in the
// output register. a colour request for an id not below NODES goes from accept
// straight to ST_PICK with an empty free set. one request is in flight at a
// time; a finished result sits in the output register while the next request
// is taken. the user writes num_colours only while the block is idle, unchecked.
module graph_colour_select
    import gcs_pkg::*;
#(
    parameter int NODES       = 64,
    parameter int MAX_COLOURS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_wr_en,
    input  logic [NCOL_W-1:0]    cfg_wr_data,    // num_colours

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // node[5:0], neighbour[11:6], zero
    input  logic                 s_axis_tuser,   // req_type

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // node_out[5:0], colour[10:6], zero
    output logic                 m_axis_tuser    // coloured
);

    localparam int AW = $clog2(NODES);
    localparam int CW = (MAX_COLOURS > 1) ? $clog2(MAX_COLOURS) : 1;
    localparam int KW = $clog2(MAX_COLOURS + 1);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_EDGE_WR,
        ST_ROW_WAIT,
        ST_SCAN,
        ST_SCAN_END,
        ST_PICK
    } state_t;

    state_t                 state_reg, state_next;
    logic [NCOL_W-1:0]      ncol_reg;
    logic [NODE_W-1:0]      node_reg, node_next;
    logic [NODE_W-1:0]      nbr_reg, nbr_next;
    logic [NODES-1:0]       row_buf_reg, row_buf_next;
    logic                   row_full_reg, row_full_next;
    logic [MAX_COLOURS-1:0] free_reg, free_next;
    logic [AW-1:0]          scan_a_reg, scan_a_next;
    logic [AW-1:0]          eval_a_reg, eval_a_next;
    logic                   eval_vld_reg, eval_vld_next;
    logic                   out_vld_reg, out_vld_next;
    logic [NODE_W-1:0]      out_node_reg, out_node_next;
    logic [COLOUR_W-1:0]    out_colour_reg, out_colour_next;
    logic                   out_found_reg, out_found_next;

    // effective colour count and the initial free set
    logic [KW-1:0]          k_eff;
    logic [MAX_COLOURS-1:0] init_mask;

    // request field decode
    logic [NODE_W-1:0]      in_node;
    logic [NODE_W-1:0]      in_nbr;
    logic [AW+NODE_W-1:0]   in_node_ext;
    logic [AW+NODE_W-1:0]   node_ext;
    logic [AW+NODE_W-1:0]   nbr_ext;
    logic [AW-1:0]          in_node_idx;
    logic [AW-1:0]          node_idx;
    logic [AW-1:0]          nbr_idx;
    logic                   in_node_ok;
    logic                   in_nbr_ok;

    // memory ports
    logic                   adj_rd_en;
    logic [AW-1:0]          adj_rd_addr;
    logic [NODES-1:0]       adj_rd_data;
    logic                   adj_wr_en;
    logic [NODES-1:0]       adj_wr_data;
    logic                   col_rd_en;
    logic [CW-1:0]          col_rd;
    logic                   col_wr_en;
    logic                   alloc_eval;
    logic                   alloc_own;

    // scan evaluation and colour pick
    logic                   hit;
    logic [MAX_COLOURS-1:0] clr;
    logic                   pick_found;
    logic [CW-1:0]          pick_idx;
    logic [CW+COLOUR_W-1:0] pick_ext;
    logic                   out_free;
    logic                   accept;

    assign in_node     = s_axis_tdata[NODE_W-1:0];
    assign in_nbr      = s_axis_tdata[2*NODE_W-1:NODE_W];
    assign in_node_ext = {{AW{1'b0}}, in_node};
    assign node_ext    = {{AW{1'b0}}, node_reg};
    assign nbr_ext     = {{AW{1'b0}}, nbr_reg};
    assign in_node_idx = in_node_ext[AW-1:0];
    assign node_idx    = node_ext[AW-1:0];
    assign nbr_idx     = nbr_ext[AW-1:0];
    assign in_node_ok  = 32'(in_node) < NODES;
    assign in_nbr_ok   = 32'(in_nbr) < NODES;

    assign k_eff = (32'(ncol_reg) > MAX_COLOURS) ? KW'(MAX_COLOURS) : KW'(ncol_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_COLOURS; i++)
        begin
            init_mask[i] = i < 32'(k_eff);
        end
    end

    // config register; the user writes it only while idle, the block does not check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncol_reg <= NCOL_RESET;
        end
        else if (cfg_wr_en)
        begin
            ncol_reg <= cfg_wr_data;
        end
    end

    assign s_axis_tready = state_reg == ST_IDLE;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_vld_reg || m_axis_tready;

    gcs_adj_ram
    #(
        .NODES (NODES),
        .AW    (AW)
    )
    u_adj_ram
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (adj_rd_en),
        .rd_addr (adj_rd_addr),
        .rd_data (adj_rd_data),
        .wr_en   (adj_wr_en),
        .wr_addr (node_idx),
        .wr_data (adj_wr_data)
    );

    gcs_colour_store
    #(
        .NODES (NODES),
        .AW    (AW),
        .CW    (CW)
    )
    u_colour_store
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (col_rd_en),
        .rd_addr   (scan_a_reg),
        .rd_colour (col_rd),
        .wr_en     (col_wr_en),
        .wr_addr   (node_idx),
        .wr_colour (pick_idx),
        .chk_addr  (eval_a_reg),
        .chk_alloc (alloc_eval),
        .own_addr  (node_idx),
        .own_alloc (alloc_own)
    );

    gcs_pick
    #(
        .MAX_COLOURS (MAX_COLOURS),
        .CW          (CW)
    )
    u_pick
    (
        .free_mask (free_reg),
        .found     (pick_found),
        .idx       (pick_idx)
    );

    assign pick_ext = {{COLOUR_W{1'b0}}, pick_idx};

    // row read: own row when it has neighbours, else column bit of row a
    assign hit = row_full_reg ? row_buf_reg[eval_a_reg] : adj_rd_data[node_idx];

    always_comb
    begin
        for (int i = 0; i < MAX_COLOURS; i++)
        begin
            clr[i] = eval_vld_reg && hit &&
                     ((row_full_reg && 32'(eval_a_reg) == i) ||
                      (alloc_eval && 32'(col_rd) == i));
        end
    end

    // read-modify-write of the source row for an edge
    assign adj_wr_en   = state_reg == ST_EDGE_WR;
    assign adj_wr_data = adj_rd_data | (NODES'(1) << nbr_idx);

    assign col_rd_en = state_reg == ST_SCAN;
    // stored colour is kept on later successes
    assign col_wr_en = (state_reg == ST_PICK) && out_free && pick_found && !alloc_own;

    always_comb
    begin
        state_next      = state_reg;
        node_next       = node_reg;
        nbr_next        = nbr_reg;
        row_buf_next    = row_buf_reg;
        row_full_next   = row_full_reg;
        free_next       = free_reg;
        scan_a_next     = scan_a_reg;
        eval_a_next     = scan_a_reg;
        eval_vld_next   = 1'b0;
        out_vld_next    = out_vld_reg && !m_axis_tready;
        out_node_next   = out_node_reg;
        out_colour_next = out_colour_reg;
        out_found_next  = out_found_reg;
        adj_rd_en       = 1'b0;
        adj_rd_addr     = scan_a_reg;

        case (state_reg)
            ST_IDLE:
            begin
                adj_rd_addr = in_node_idx;
                if (accept)
                begin
                    node_next = in_node;
                    nbr_next  = in_nbr;
                    if (s_axis_tuser == REQ_EDGE)
                    begin
                        // edges touching an out-of-range id are dropped
                        if (in_node_ok && in_nbr_ok)
                        begin
                            adj_rd_en  = 1'b1;
                            state_next = ST_EDGE_WR;
                        end
                    end
                    else if (in_node_ok)
                    begin
                        adj_rd_en  = 1'b1;
                        state_next = ST_ROW_WAIT;
                    end
                    else
                    begin
                        // unknown node: empty free set, reported as a failure
                        free_next  = '0;
                        state_next = ST_PICK;
                    end
                end
            end

            ST_EDGE_WR:
            begin
                state_next = ST_IDLE;
            end

            ST_ROW_WAIT:
            begin
                row_buf_next  = adj_rd_data;
                row_full_next = |adj_rd_data;
                free_next     = init_mask;
                scan_a_next   = '0;
                state_next    = ST_SCAN;
            end

            ST_SCAN:
            begin
                adj_rd_en     = 1'b1;
                eval_vld_next = 1'b1;
                free_next     = free_reg & ~clr;
                if (scan_a_reg == AW'(NODES - 1))
                begin
                    state_next = ST_SCAN_END;
                end
                else
                begin
                    scan_a_next = scan_a_reg + AW'(1);
                end
            end

            ST_SCAN_END:
            begin
                free_next  = free_reg & ~clr;
                state_next = ST_PICK;
            end

            ST_PICK:
            begin
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_node_next   = node_reg;
                    out_colour_next = pick_ext[COLOUR_W-1:0];
                    out_found_next  = pick_found;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_reg       <= '0;
            nbr_reg        <= '0;
            row_buf_reg    <= '0;
            row_full_reg   <= 1'b0;
            free_reg       <= '0;
            scan_a_reg     <= '0;
            eval_a_reg     <= '0;
            eval_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
            out_node_reg   <= '0;
            out_colour_reg <= '0;
            out_found_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_reg       <= node_next;
            nbr_reg        <= nbr_next;
            row_buf_reg    <= row_buf_next;
            row_full_reg   <= row_full_next;
            free_reg       <= free_next;
            scan_a_reg     <= scan_a_next;
            eval_a_reg     <= eval_a_next;
            eval_vld_reg   <= eval_vld_next;
            out_vld_reg    <= out_vld_next;
            out_node_reg   <= out_node_next;
            out_colour_reg <= out_colour_next;
            out_found_reg  <= out_found_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = M_TDATA_W'({out_colour_reg, out_node_reg});
    assign m_axis_tuser  = out_found_reg;

    // a granted colour lies below the effective colour count
    a_colour_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_found_reg |-> 32'(out_colour_reg) < 32'(k_eff))
        else $error("granted colour not below colour count");

    // a failed request reports colour zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_found_reg |-> out_colour_reg == '0)
        else $error("failed request carries a colour");

    // a node's colour is stored only once
    a_store_once: assert property (@(posedge clk) disable iff (!rst_n)
        col_wr_en |-> !alloc_own)
        else $error("colour store overwrites an allocated node");

    // every row write back follows its row read
    a_edge_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        adj_wr_en |-> $past(adj_rd_en))
        else $error("adjacency write without preceding read");

endmodule
